// ===== src/lmgs_pkg.sv =====
// ----------------------------------------------------------------------------
// lmgs_pkg: shared types and constants of the LED matrix scan engine
// Field widths, store geometry, command codes and the queue entry format.
// ----------------------------------------------------------------------------
package lmgs_pkg;

  // Store geometry
  localparam int MAX_FRAMES = 8;
  localparam int ROWS       = 8;
  localparam int CHANNELS   = 32;

  localparam int FRAME_W    = 3;
  localparam int ROW_W      = 3;
  localparam int CHAN_W     = 5;
  localparam int GRAY_W     = 12;
  localparam int DC_W       = 6;
  localparam int ADDR_W     = FRAME_W + ROW_W + CHAN_W;
  localparam int DEPTH      = MAX_FRAMES * ROWS * CHANNELS;

  // Serialiser geometry
  localparam int SCAN_BITS  = CHANNELS * GRAY_W;
  localparam int DC_BITS    = CHANNELS * DC_W;
  localparam int SCAN_BYTES = SCAN_BITS / 8;
  localparam int DC_BYTES   = DC_BITS / 8;
  localparam int BYTE_CNT_W = 6;

  // Command queue between front and back
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;

  // Configuration register defaults and address decode
  localparam logic [3:0] FRAMES_RESET  = 4'd5;
  localparam logic [7:0] REPEATS_RESET = 8'd40;
  localparam logic       REG_FRAMES    = 1'b0;
  localparam logic       REG_REPEATS   = 1'b1;

  typedef enum logic [1:0] {
    OP_GRAY_WR = 2'd0,
    OP_DC_WR   = 2'd1,
    OP_SEND_DC = 2'd2,
    OP_SCAN    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOAD,
    BK_EMIT
  } back_state_t;

  // One decoded command waiting for the back end
  typedef struct packed {
    op_t                op;
    logic [ADDR_W-1:0]  addr;
    logic [GRAY_W-1:0]  level;
  } q_entry_t;

  // Queue status towards the back end
  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

// ===== src/lmgs_front.sv =====
// ----------------------------------------------------------------------------
// lmgs_front: command intake and queue
// Accepts host commands, drops gray writes outside the store, forms the store
// address and holds decoded commands in a short queue for the back end.
// ----------------------------------------------------------------------------
module lmgs_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [1:0]                          cmd,
  input  logic [lmgs_pkg::FRAME_W-1:0]        frame_sel,
  input  logic [lmgs_pkg::ROW_W-1:0]          row_sel,
  input  logic [lmgs_pkg::CHAN_W-1:0]         channel_sel,
  input  logic [lmgs_pkg::GRAY_W-1:0]         level,
  input  logic                                take,
  output lmgs_pkg::q_status_t                 q_st,
  output lmgs_pkg::q_entry_t                  q_head
);

  lmgs_pkg::q_entry_t                 queue [lmgs_pkg::QDEPTH];
  lmgs_pkg::q_entry_t                 entry_in;
  logic [lmgs_pkg::QPTR_W-1:0]        wr_ptr;
  logic [lmgs_pkg::QPTR_W-1:0]        rd_ptr;
  logic [lmgs_pkg::QCNT_W-1:0]        count;
  logic                               in_range;
  logic                               accept;
  logic                               enq;

  // Classify: gray writes outside the frame store are dropped
  always_comb begin
    entry_in.op    = lmgs_pkg::op_t'(cmd);
    entry_in.addr  = {frame_sel, row_sel, channel_sel};
    entry_in.level = level;
    in_range = ({1'b0, frame_sel} < 4'(lmgs_pkg::MAX_FRAMES)) &&
               ({1'b0, row_sel}   < 4'(lmgs_pkg::ROWS));
  end

  assign full   = (count == lmgs_pkg::QCNT_W'(lmgs_pkg::QDEPTH));
  assign accept = push && !full;
  assign enq    = accept && (in_range || (entry_in.op != lmgs_pkg::OP_GRAY_WR));

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq)  wr_ptr <= wr_ptr + 1'b1;
      if (take) rd_ptr <= rd_ptr + 1'b1;
      case ({enq, take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (enq) queue[wr_ptr] <= entry_in;
  end

  assign q_head   = queue[rd_ptr];
  assign q_st.valid = (count != '0);
  assign q_st.full  = full;

endmodule

// ===== src/lmgs_back.sv =====
// ----------------------------------------------------------------------------
// lmgs_back: stores, scan counters and byte serialiser
// Executes queued commands in order: store writes, dot-correction send and
// row scan. A 384-bit shift register is loaded from the frame store (one
// channel a cycle) or from the dot-correction store, then shifted out a byte
// at a time into the output register.
// ----------------------------------------------------------------------------
module lmgs_back (
  input  logic                          clk,
  input  logic                          rst,
  input  lmgs_pkg::q_status_t           q_st,
  input  lmgs_pkg::q_entry_t            q_head,
  output logic                          take,
  input  logic [3:0]                    frames_in_use,
  input  logic [7:0]                    repeats_per_frame,
  output logic                          out_valid,
  input  logic                          pop,
  output logic [7:0]                    spi_byte,
  output logic                          dc_mode,
  output logic [2:0]                    row_code,
  output logic [2:0]                    frame_shown,
  output logic                          last
);

  lmgs_pkg::back_state_t                state;
  lmgs_pkg::back_state_t                state_next;

  logic [lmgs_pkg::GRAY_W-1:0]          gray_mem [lmgs_pkg::DEPTH];
  logic [lmgs_pkg::GRAY_W-1:0]          rdata;
  logic [lmgs_pkg::DC_W-1:0]            dc_store [lmgs_pkg::CHANNELS];
  logic [lmgs_pkg::DC_BITS-1:0]         dc_flat;

  logic [lmgs_pkg::SCAN_BITS-1:0]       shreg;
  logic [lmgs_pkg::CHAN_W:0]            rd_cnt;
  logic                                 rd_en;
  logic                                 rd_vld;
  logic [lmgs_pkg::FRAME_W+lmgs_pkg::ROW_W-1:0] row_base;
  logic [lmgs_pkg::BYTE_CNT_W-1:0]      byte_cnt;
  logic [lmgs_pkg::BYTE_CNT_W-1:0]      last_idx;
  logic                                 cap_dc;
  logic [2:0]                           cap_rc;
  logic [2:0]                           cap_fr;
  logic                                 emit;
  logic                                 out_ready;
  logic                                 mem_we;

  logic [lmgs_pkg::ROW_W-1:0]           cur_row;
  logic [7:0]                           refresh_cnt;
  logic [lmgs_pkg::FRAME_W-1:0]         cur_frame;
  logic                                 going_down;

  logic [7:0]                           refresh_inc;
  logic [7:0]                           rep;
  logic                                 frame_done;
  logic [3:0]                           n_frames;
  logic [3:0]                           cf4;
  logic [lmgs_pkg::FRAME_W-1:0]         frame_next;
  logic                                 down_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= lmgs_pkg::BK_IDLE;
    else     state <= state_next;
  end

  // Sequencer: next state and strobes
  always_comb begin
    state_next = state;
    take       = 1'b0;
    rd_en      = 1'b0;
    emit       = 1'b0;
    out_ready  = !out_valid || pop;
    unique case (state)
      lmgs_pkg::BK_IDLE: begin
        if (q_st.valid) begin
          take = 1'b1;
          case (q_head.op)
            lmgs_pkg::OP_SEND_DC: state_next = lmgs_pkg::BK_EMIT;
            lmgs_pkg::OP_SCAN:    state_next = lmgs_pkg::BK_LOAD;
            default:              state_next = lmgs_pkg::BK_IDLE;
          endcase
        end
      end
      lmgs_pkg::BK_LOAD: begin
        if (rd_cnt[lmgs_pkg::CHAN_W]) state_next = lmgs_pkg::BK_EMIT;
        else                          rd_en      = 1'b1;
      end
      lmgs_pkg::BK_EMIT: begin
        if (out_ready) begin
          emit = 1'b1;
          if (byte_cnt == last_idx) state_next = lmgs_pkg::BK_IDLE;
        end
      end
      default: state_next = lmgs_pkg::BK_IDLE;
    endcase
  end

  assign mem_we = take && (q_head.op == lmgs_pkg::OP_GRAY_WR);

  // Frame store: one write or one read a cycle, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) gray_mem[q_head.addr] <= q_head.level;
    if (rd_en)  rdata <= gray_mem[{row_base, ~rd_cnt[lmgs_pkg::CHAN_W-1:0]}];
  end

  // Dot-correction values packed with channel 31 on top
  always_comb begin
    for (int i = 0; i < lmgs_pkg::CHANNELS; i++) begin
      dc_flat[i*lmgs_pkg::DC_W +: lmgs_pkg::DC_W] = dc_store[i];
    end
  end

  // Refresh and frame sequencing for the end of a row
  always_comb begin
    refresh_inc = refresh_cnt + 8'd1;
    rep         = (repeats_per_frame == 8'd0) ? 8'd1 : repeats_per_frame;
    frame_done  = (refresh_inc >= rep) || (refresh_inc == 8'd0);
    if (frames_in_use == 4'd0)      n_frames = 4'd1;
    else if (frames_in_use > 4'd8)  n_frames = 4'd8;
    else                            n_frames = frames_in_use;
    cf4        = {1'b0, cur_frame};
    frame_next = '0;
    down_next  = 1'b0;
    if (!going_down) begin
      if (cf4 + 4'd1 < n_frames) begin
        frame_next = cur_frame + 1'b1;
      end else if (n_frames >= 4'd3 && cf4 + 4'd1 == n_frames) begin
        down_next  = 1'b1;
        frame_next = 3'(n_frames - 4'd2);
      end
    end else begin
      if (cf4 >= 4'd2 && cf4 - 4'd1 < n_frames) begin
        down_next  = 1'b1;
        frame_next = cur_frame - 1'b1;
      end
    end
  end

  // Control state: stores, counters, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      rd_vld      <= 1'b0;
      cur_row     <= '0;
      refresh_cnt <= '0;
      cur_frame   <= '0;
      going_down  <= 1'b0;
      for (int i = 0; i < lmgs_pkg::CHANNELS; i++) dc_store[i] <= '0;
    end else begin
      rd_vld <= rd_en;
      if (emit)     out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
      if (take) begin
        case (q_head.op)
          lmgs_pkg::OP_DC_WR: begin
            dc_store[q_head.addr[lmgs_pkg::CHAN_W-1:0]] <= q_head.level[lmgs_pkg::DC_W-1:0];
          end
          lmgs_pkg::OP_SCAN: begin
            if (cur_row == lmgs_pkg::ROW_W'(lmgs_pkg::ROWS - 1)) begin
              cur_row <= '0;
              if (frame_done) begin
                refresh_cnt <= '0;
                cur_frame   <= frame_next;
                going_down  <= down_next;
              end else begin
                refresh_cnt <= refresh_inc;
              end
            end else begin
              cur_row <= cur_row + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Serialiser datapath
  always_ff @(posedge clk) begin
    if (take && q_head.op == lmgs_pkg::OP_SEND_DC) begin
      shreg    <= {dc_flat, {(lmgs_pkg::SCAN_BITS - lmgs_pkg::DC_BITS){1'b0}}};
      cap_dc   <= 1'b1;
      cap_rc   <= '0;
      cap_fr   <= '0;
      last_idx <= lmgs_pkg::BYTE_CNT_W'(lmgs_pkg::DC_BYTES - 1);
      byte_cnt <= '0;
    end
    if (take && q_head.op == lmgs_pkg::OP_SCAN) begin
      cap_dc   <= 1'b0;
      cap_rc   <= {cur_row[0], cur_row[1], cur_row[2]};
      cap_fr   <= cur_frame;
      last_idx <= lmgs_pkg::BYTE_CNT_W'(lmgs_pkg::SCAN_BYTES - 1);
      byte_cnt <= '0;
      rd_cnt   <= '0;
      row_base <= {cur_frame, cur_row};
    end
    if (rd_en) rd_cnt <= rd_cnt + 1'b1;
    // load one channel, first read ends on top
    if (rd_vld) begin
      shreg <= {shreg[lmgs_pkg::SCAN_BITS-lmgs_pkg::GRAY_W-1:0], rdata};
    end
    if (emit) begin
      spi_byte    <= shreg[lmgs_pkg::SCAN_BITS-1 -: 8];
      dc_mode     <= cap_dc;
      row_code    <= cap_rc;
      frame_shown <= cap_fr;
      last        <= (byte_cnt == last_idx);
      shreg       <= {shreg[lmgs_pkg::SCAN_BITS-9:0], 8'h00};
      byte_cnt    <= byte_cnt + 1'b1;
    end
  end

endmodule

// ===== src/led_matrix_grayscale_scan.sv =====
// ----------------------------------------------------------------------------
// led_matrix_grayscale_scan: row-multiplexed LED driver refresh engine
// A pushed command is written into the queue; a store write is done when the back
// end takes it. A scan reads 32 channels from the single-port frame store, then
// sends 48 bytes at one per cycle while the byte side does not stall.
// A dot-correction send gives 24 bytes, also one per cycle unless the byte side stalls.
// Reset: counters, dot-correction store and queue cleared, config 5 and 40;
// the frame store is not cleared.
// ----------------------------------------------------------------------------
module led_matrix_grayscale_scan (
  input  logic        clk,
  input  logic        rst,
  // command side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd,
  input  logic [2:0]  frame_sel,
  input  logic [2:0]  row_sel,
  input  logic [4:0]  channel_sel,
  input  logic [11:0] level,
  // byte side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  spi_byte,
  output logic        dc_mode,
  output logic [2:0]  row_code,
  output logic [2:0]  frame_shown,
  output logic        last,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0]           frames_in_use;
  logic [7:0]           repeats_per_frame;
  logic                 cfg_wr;
  lmgs_pkg::q_status_t  q_st;
  lmgs_pkg::q_entry_t   q_head;
  logic                 take;
  logic                 out_valid;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use     <= lmgs_pkg::FRAMES_RESET;
      repeats_per_frame <= lmgs_pkg::REPEATS_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == lmgs_pkg::REG_FRAMES) frames_in_use     <= pwdata[3:0];
      else                                  repeats_per_frame <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == lmgs_pkg::REG_REPEATS) ? {24'd0, repeats_per_frame}
                                                      : {28'd0, frames_in_use};

  lmgs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .cmd         (cmd),
    .frame_sel   (frame_sel),
    .row_sel     (row_sel),
    .channel_sel (channel_sel),
    .level       (level),
    .take        (take),
    .q_st        (q_st),
    .q_head      (q_head)
  );

  lmgs_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_st              (q_st),
    .q_head            (q_head),
    .take              (take),
    .frames_in_use     (frames_in_use),
    .repeats_per_frame (repeats_per_frame),
    .out_valid         (out_valid),
    .pop               (pop),
    .spi_byte          (spi_byte),
    .dc_mode           (dc_mode),
    .row_code          (row_code),
    .frame_shown       (frame_shown),
    .last              (last)
  );

  assign empty = !out_valid;

  // Back end only takes from a non-empty queue
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    take |-> q_st.valid)
    else $error("back end took from an empty queue");

  // A full queue is never reported empty
  a_full_valid: assert property (@(posedge clk) disable iff (rst)
    q_st.full |-> q_st.valid)
    else $error("queue full and empty at once");

  // Dot-correction bytes carry no row or frame
  a_dc_fields: assert property (@(posedge clk) disable iff (rst)
    (!empty && dc_mode) |-> (row_code == 3'd0 && frame_shown == 3'd0))
    else $error("dot-correction byte with row or frame set");

  // A waiting byte stays put until its transfer
  a_hold_byte: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(spi_byte) && $stable(last) &&
                          $stable(dc_mode)))
    else $error("waiting byte changed before transfer");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for the LED matrix grayscale scan engine
// Commands go in through the push/full queue port and the bytes come back on
// the empty/pop side. An in-bench predictor keeps its own copy of the frame
// store, the dot-correction store, the row/refresh/frame counters and the
// two configuration registers. It queues the bytes that each accepted
// command should produce, and every popped byte is checked against the oldest
// one. Both sides idle at random, and one phase holds the byte side off so that
// the command side stalls.
// ----------------------------------------------------------------------------
module tb;
  import lmgs_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 32;
  localparam int END_CYCLES     = 200;
  localparam int TIMEOUT_CYCLES = 10_000_000;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_ITEMS   = 400;

  // One byte as it leaves the serialiser
  typedef struct packed {
    logic [7:0] data;
    logic       dc;
    logic [2:0] rowc;
    logic [2:0] frame;
    logic       lst;
  } spi_beat_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [1:0]  cmd;
  logic [2:0]  frame_sel;
  logic [2:0]  row_sel;
  logic [4:0]  channel_sel;
  logic [11:0] level;
  logic        empty;
  logic        pop;
  logic [7:0]  spi_byte;
  logic        dc_mode;
  logic [2:0]  row_code;
  logic [2:0]  frame_shown;
  logic        last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  led_matrix_grayscale_scan u_dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .cmd         (cmd),
    .frame_sel   (frame_sel),
    .row_sel     (row_sel),
    .channel_sel (channel_sel),
    .level       (level),
    .empty       (empty),
    .pop         (pop),
    .spi_byte    (spi_byte),
    .dc_mode     (dc_mode),
    .row_code    (row_code),
    .frame_shown (frame_shown),
    .last        (last),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Predictor state
  logic [GRAY_W-1:0] gray_img [DEPTH];
  logic [DC_W-1:0]   dc_img [CHANNELS];
  logic [2:0]        scan_row;
  logic [7:0]        scan_refresh;
  logic [2:0]        scan_frame;
  logic              scan_desc;
  logic [3:0]        cfg_frames;
  logic [7:0]        cfg_repeats;

  spi_beat_t spi_bytes_due [$];

  // Traffic shaping shared between the test tasks and the byte sink
  bit tx_steady;
  bit rx_steady;
  bit hold_req;

  int err_count;
  int items_sent;
  int scans_sent;
  int dc_sends;
  int settings_applied;
  int bytes_checked;
  int full_stall_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Watchdog
  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Regression FAIL");
    $finish;
  end

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("[%0t] ERROR: %s", $time, msg);
  endtask

  // Mostly short idle stretches, now and then a long one
  function automatic int unsigned gap_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(15, 50);
  endfunction

  function automatic logic [11:0] rand_level();
    case ($urandom_range(0, 7))
      0: return 12'h000;
      1: return 12'hfff;
      default: return 12'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Predictor: applies one command and queues the bytes it gives
  // --------------------------------------------------------------------------
  task automatic predict_spi_bytes(input op_t op, input logic [2:0] fr,
                                   input logic [2:0] rw, input logic [4:0] ch,
                                   input logic [11:0] lv);
    logic [SCAN_BITS-1:0] stream;
    logic [DC_BITS-1:0]   dcs;
    logic [2:0]           rc;
    logic [7:0]           rep;
    spi_beat_t            beat;
    int                   n, c, b, f;
    case (op)
      OP_GRAY_WR: gray_img[{fr, rw, ch}] = lv;
      OP_DC_WR:   dc_img[ch] = lv[DC_W-1:0];
      OP_SEND_DC: begin
        // channel 31 leads the stream
        for (c = 0; c < CHANNELS; c++) dcs[c*DC_W +: DC_W] = dc_img[c];
        for (b = 0; b < DC_BYTES; b++) begin
          beat = '{data: dcs[DC_BITS-1-8*b -: 8], dc: 1'b1, rowc: 3'd0, frame: 3'd0,
                   lst: (b == DC_BYTES - 1)};
          spi_bytes_due.push_back(beat);
        end
      end
      OP_SCAN: begin
        for (c = 0; c < CHANNELS; c++)
          stream[c*GRAY_W +: GRAY_W] = gray_img[{scan_frame, scan_row, 5'(c)}];
        rc = {scan_row[0], scan_row[1], scan_row[2]};
        for (b = 0; b < SCAN_BYTES; b++) begin
          beat = '{data: stream[SCAN_BITS-1-8*b -: 8], dc: 1'b0, rowc: rc,
                   frame: scan_frame, lst: (b == SCAN_BYTES - 1)};
          spi_bytes_due.push_back(beat);
        end
        // row, refresh and frame counters
        if (scan_row == 3'(ROWS - 1)) begin
          scan_row = 3'd0;
          scan_refresh = scan_refresh + 8'd1;
          rep = (cfg_repeats == 8'd0) ? 8'd1 : cfg_repeats;
          if (scan_refresh >= rep || scan_refresh == 8'd0) begin
            scan_refresh = 8'd0;
            // ping-pong step; zero counts as one frame, large counts saturate
            n = (cfg_frames == 4'd0) ? 1 : ((cfg_frames > MAX_FRAMES) ? MAX_FRAMES
                                                                      : int'(cfg_frames));
            f = int'(scan_frame);
            if (!scan_desc) begin
              if (f + 1 < n) begin
                scan_frame = 3'(f + 1);
              end else if (n >= 3 && f + 1 == n) begin
                scan_desc = 1'b1;
                scan_frame = 3'(n - 2);
              end else begin
                scan_frame = 3'd0;
              end
            end else begin
              if (f >= 2 && f - 1 < n) begin
                scan_frame = 3'(f - 1);
              end else begin
                scan_desc = 1'b0;
                scan_frame = 3'd0;
              end
            end
          end
        end else begin
          scan_row = scan_row + 3'd1;
        end
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Command side: one transfer, then an optional idle gap
  // --------------------------------------------------------------------------
  task automatic send_cmd(input op_t op, input logic [2:0] fr, input logic [2:0] rw,
                          input logic [4:0] ch, input logic [11:0] lv);
    int unsigned g;
    cmd         <= op;
    frame_sel   <= fr;
    row_sel     <= rw;
    channel_sel <= ch;
    level       <= lv;
    push        <= 1'b1;
    do @(posedge clk); while (full);
    predict_spi_bytes(op, fr, rw, ch, lv);
    items_sent++;
    if (op == OP_SCAN) scans_sent++;
    if (op == OP_SEND_DC) dc_sends++;
    g = 0;
    if (!tx_steady && $urandom_range(0, 2) == 0) g = gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_scans(input int count);
    int i;
    for (i = 0; i < count; i++)
      send_cmd(OP_SCAN, 3'($urandom), 3'($urandom), 5'($urandom), rand_level());
  endtask

  // Stop offering and wait for every due byte, then let the back end settle
  task automatic wait_drained(input int settle);
    push <= 1'b0;
    @(posedge clk);
    while (spi_bytes_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Register port
  // --------------------------------------------------------------------------
  task automatic reg_access(input logic wr, input logic idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_check(input logic idx);
    logic [31:0] rd, want;
    reg_access(1'b0, idx, 32'd0, rd);
    want = (idx == REG_FRAMES) ? {28'd0, cfg_frames} : {24'd0, cfg_repeats};
    if (rd !== want)
      note_error($sformatf("register %0d read %08h, expected %08h", idx, rd, want));
  endtask

  // Only ever called with the engine idle
  task automatic configure(input logic [31:0] frames, input logic [31:0] repeats);
    logic [31:0] unused;
    wait_drained(SETTLE_CYCLES);
    reg_access(1'b1, REG_FRAMES, frames, unused);
    cfg_frames = frames[3:0];
    reg_check(REG_FRAMES);
    reg_access(1'b1, REG_REPEATS, repeats, unused);
    cfg_repeats = repeats[7:0];
    reg_check(REG_REPEATS);
    settings_applied++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Register defaults and a dot-correction send of the cleared store
  task automatic test_reset_state();
    reg_check(REG_FRAMES);
    reg_check(REG_REPEATS);
    send_cmd(OP_SEND_DC, 3'd0, 3'd0, 5'd0, 12'd0);
    wait_drained(0);
  endtask

  // Every gray entry gets a value before any scan can read it
  task automatic test_fill_frame_store();
    int a;
    tx_steady = 1'b1;
    for (a = 0; a < DEPTH; a++) send_cmd(OP_GRAY_WR, a[10:8], a[7:5], a[4:0], rand_level());
    tx_steady = 1'b0;
    wait_drained(0);
  endtask

  // Field extremes, each command, full-range and masked dot correction
  task automatic test_directed_commands();
    send_cmd(OP_DC_WR, 3'd0, 3'd0, 5'd0, 12'hfff);
    send_cmd(OP_DC_WR, 3'd7, 3'd7, 5'd31, 12'hfc0);
    send_cmd(OP_DC_WR, 3'd0, 3'd0, 5'd31, 12'h02a);
    send_cmd(OP_DC_WR, 3'd5, 3'd2, 5'd1, 12'h015);
    send_cmd(OP_SEND_DC, 3'd7, 3'd7, 5'd31, 12'hfff);
    send_cmd(OP_GRAY_WR, 3'd0, 3'd0, 5'd0, 12'hfff);
    send_cmd(OP_GRAY_WR, 3'd0, 3'd0, 5'd31, 12'h000);
    send_cmd(OP_GRAY_WR, 3'd0, 3'd0, 5'd16, 12'h800);
    send_cmd(OP_GRAY_WR, 3'd0, 3'd0, 5'd15, 12'h001);
    send_cmd(OP_SCAN, 3'd0, 3'd0, 5'd0, 12'h000);
    send_cmd(OP_GRAY_WR, 3'd7, 3'd7, 5'd31, 12'hfff);
    // remaining rows of the refresh, every row code
    send_scans(7);
    send_cmd(OP_SEND_DC, 3'd0, 3'd0, 5'd0, 12'h000);
    wait_drained(0);
  endtask

  // Frame sequencing for one, two, several and out-of-range frame counts
  task automatic test_ping_pong();
    int pp_frames [6]  = '{1, 2, 3, 8, 0, 15};
    int pp_repeats [6] = '{1, 1, 1, 1, 0, 3};
    int pp_scans [6]   = '{24, 40, 48, 120, 24, 56};
    int i;
    for (i = 0; i < 6; i++) begin
      configure(pp_frames[i], pp_repeats[i]);
      rx_steady = (i % 2 == 1);
      send_scans(pp_scans[i]);
    end
    rx_steady = 1'b0;
  endtask

  // Frame count shrinks while a higher frame is on show
  task automatic test_frame_shrink();
    int guard;
    configure(8, 1);
    guard = 0;
    while (!(scan_frame == 3'd6 && !scan_desc) && guard < 200) begin
      send_scans(1);
      guard++;
    end
    send_scans(3);
    configure(3, 1);
    send_scans(29);
    // same on the way down
    configure(8, 1);
    guard = 0;
    while (!(scan_frame == 3'd5 && scan_desc) && guard < 200) begin
      send_scans(1);
      guard++;
    end
    send_scans(2);
    configure(2, 1);
    send_scans(30);
  endtask

  // Byte side held off while scans are queued, so the command queue backs up
  task automatic test_backpressure();
    wait_drained(0);
    tx_steady = 1'b1;
    hold_req  = 1'b1;
    send_scans(12);
    send_cmd(OP_SEND_DC, 3'd0, 3'd0, 5'd0, 12'd0);
    tx_steady = 1'b0;
    wait_drained(0);
  endtask

  // Random command mix over a few register settings
  task automatic test_random_traffic();
    int   chunk, i;
    int   r;
    op_t  op;
    for (chunk = 0; chunk < 4; chunk++) begin
      case (chunk)
        0: configure($urandom_range(1, 8), 1);
        1: configure($urandom_range(0, 15), 255);
        2: configure($urandom_range(0, 15), 0);
        default: configure($urandom_range(0, 15), $urandom_range(1, 4));
      endcase
      tx_steady = (chunk == 2);
      rx_steady = (chunk == 2);
      for (i = 0; i < RANDOM_ITEMS / 4; i++) begin
        r = $urandom_range(0, 99);
        if (r < 45) op = OP_SCAN;
        else if (r < 75) op = OP_GRAY_WR;
        else if (r < 90) op = OP_DC_WR;
        else op = OP_SEND_DC;
        send_cmd(op, 3'($urandom), 3'($urandom), 5'($urandom), rand_level());
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Byte sink: random stalls, steady stretches and one long hold-off
  // --------------------------------------------------------------------------
  initial begin : byte_sink
    int unsigned hold_left;
    int unsigned stall_left;
    hold_left  = 0;
    stall_left = 0;
    forever begin
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        if (!rx_steady && $urandom_range(0, 7) == 0) stall_left = gap_len();
      end
      @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Byte checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : byte_check
    spi_beat_t want;
    if (!rst && push && full) full_stall_cycles++;
    if (!rst && pop && !empty) begin
      bytes_checked++;
      if (spi_bytes_due.size() == 0) begin
        note_error($sformatf("byte %02h with nothing due (dc_mode %0d last %0d)",
                             spi_byte, dc_mode, last));
      end else begin
        want = spi_bytes_due.pop_front();
        if (spi_byte !== want.data || dc_mode !== want.dc || row_code !== want.rowc ||
            frame_shown !== want.frame || last !== want.lst)
          note_error($sformatf({"byte mismatch (expected/actual): spi_byte %02h/%02h ",
                                "dc_mode %0d/%0d row_code %0d/%0d frame_shown %0d/%0d ",
                                "last %0d/%0d"},
                               want.data, spi_byte, want.dc, dc_mode, want.rowc, row_code,
                               want.frame, frame_shown, want.lst, last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : run
    int c;
    rst         <= 1'b1;
    push        <= 1'b0;
    cmd         <= OP_GRAY_WR;
    frame_sel   <= 3'd0;
    row_sel     <= 3'd0;
    channel_sel <= 5'd0;
    level       <= 12'd0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= 3'd0;
    pwdata      <= 32'd0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    hold_req  = 1'b0;

    // predictor after reset
    for (c = 0; c < CHANNELS; c++) dc_img[c] = '0;
    scan_row     = 3'd0;
    scan_refresh = 8'd0;
    scan_frame   = 3'd0;
    scan_desc    = 1'b0;
    cfg_frames   = FRAMES_RESET;
    cfg_repeats  = REPEATS_RESET;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_fill_frame_store();
    test_directed_commands();
    test_ping_pong();
    test_frame_shrink();
    test_backpressure();
    test_random_traffic();
    wait_drained(END_CYCLES);

    if (spi_bytes_due.size() != 0)
      note_error($sformatf("%0d bytes never arrived", spi_bytes_due.size()));
    $display("Covered %0d commands (%0d scans, %0d dot-correction sends) over %0d settings;",
             items_sent, scans_sent, dc_sends, settings_applied);
    $display("checked %0d bytes, command side held by full for %0d cycles, %0d errors.",
             bytes_checked, full_stall_cycles, err_count);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
